// ----- src/ssd_pkg.sv -----
// shared constants and types for the sorted set difference block
// no dependencies; imported by every module of the block
package ssd_pkg;

    localparam int B_DEPTH = 256;
    localparam int CNT_W   = $clog2(B_DEPTH + 1);
    localparam int VAL_W   = 32;
    localparam int KEPT_W  = 16;
    localparam logic [KEPT_W-1:0] KEPT_MAX = {KEPT_W{1'b1}};

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    // common control for every cell of the exclusion chain
    typedef struct packed {
        logic             shift;
        logic             wr;
        logic [VAL_W-1:0] wr_data;
    } t_cell_ctrl;

endpackage

// ----- src/ssd_cell.sv -----
// one storage cell of the exclusion chain
// depends on ssd_pkg
module ssd_cell import ssd_pkg::*; (
    input  logic             i_clk,
    input  t_cell_ctrl       i_ctrl,
    input  logic             i_sel,
    input  logic [VAL_W-1:0] i_next,
    output logic [VAL_W-1:0] o_data
);

    logic [VAL_W-1:0] r_data;
    logic [VAL_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.shift) begin
            n_data = i_next;
        end else if (i_ctrl.wr && i_sel) begin
            n_data = i_ctrl.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ----- src/ssd_chain.sv -----
// row of exclusion cells; cell 0 is the head under the merge pointer
// depends on ssd_pkg and ssd_cell
module ssd_chain import ssd_pkg::*; (
    input  logic             i_clk,
    input  t_cell_ctrl       i_ctrl,
    input  logic [CNT_W-1:0] i_fill,
    output logic [VAL_W-1:0] o_head
);

    logic [VAL_W-1:0] w_data [B_DEPTH+1];

    assign w_data[B_DEPTH] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < B_DEPTH; gi++) begin : g_cell
            ssd_cell u_cell (
                .i_clk  (i_clk),
                .i_ctrl (i_ctrl),
                .i_sel  (i_fill == CNT_W'(gi)),
                .i_next (w_data[gi+1]),
                .o_data (w_data[gi])
            );
        end
    endgenerate

    assign o_head = w_data[0];

endmodule

// ----- src/sorted_set_difference.sv -----
// sorted set difference (A minus B) by merge walk over a chain of cells
// an A request moves to S_WALK, where the pointer passes the B entries below the A
// value, one pop a cycle at the single compare of the head cell; the result is then
// registered once the output register is free; B requests write the tail, no result
// no request is taken during the walk; pops total at most B_DEPTH per problem
// reset: synchronous active-low i_rst_n clears counts, state and output valid
module sorted_set_difference import ssd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value
    input  logic        i_s_axis_tuser,   // [0] kind (0 = B element, 1 = A element)
    input  logic        i_s_axis_tlast,   // last A element of the problem
    // result channel
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [31:0] out_value, [47:32] kept_count
    output logic        o_m_axis_tuser,   // [0] kept
    output logic        o_m_axis_tlast    // out_last
);

    // control state
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_bcnt;    // B entries written this problem (depth limit)
    logic [CNT_W-1:0] r_qcnt;    // entries still at or past the pointer
    logic [KEPT_W-1:0] r_kept;
    logic             r_ovalid;

    // held A element
    logic [VAL_W-1:0] r_aval;
    logic             r_alast;

    // output register
    logic [VAL_W-1:0]  r_oval;
    logic [KEPT_W-1:0] r_ocnt;
    logic              r_okept;
    logic              r_olast;

    logic             w_in_acc;
    logic             w_out_free;
    logic             w_head_ok;
    logic             w_pop;
    logic             w_finish;
    logic             w_keep;
    logic [KEPT_W-1:0] w_kept_next;
    logic [VAL_W-1:0] w_head;
    t_cell_ctrl       w_ctrl;

    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_ovalid || i_m_axis_tready;

    // pointer still inside B: head cell holds the entry under the pointer
    assign w_head_ok  = (r_qcnt != '0);
    assign w_pop      = (r_state == S_WALK) && w_head_ok &&
                        ($signed(w_head) < $signed(r_aval));
    assign w_finish   = (r_state == S_WALK) && !w_pop && w_out_free;
    assign w_keep     = !(w_head_ok && (w_head == r_aval));
    assign w_kept_next = (w_keep && (r_kept != KEPT_MAX)) ? r_kept + 1'b1 : r_kept;

    // chain control: pop shifts every cell toward the head, B writes land at the tail
    always_comb begin
        w_ctrl.shift   = w_pop;
        w_ctrl.wr      = w_in_acc && !i_s_axis_tuser && (r_bcnt < CNT_W'(B_DEPTH));
        w_ctrl.wr_data = i_s_axis_tdata;
    end

    ssd_chain u_chain (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_fill (r_qcnt),
        .o_head (w_head)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_s_axis_tuser) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (w_finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        case (r_state)
            S_IDLE:  o_s_axis_tready = 1'b1;
            S_WALK:  o_s_axis_tready = 1'b0;
            default: o_s_axis_tready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bcnt   <= '0;
            r_qcnt   <= '0;
            r_kept   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ctrl.wr) begin
                r_bcnt <= r_bcnt + 1'b1;
                r_qcnt <= r_qcnt + 1'b1;
            end
            if (w_pop) begin
                r_qcnt <= r_qcnt - 1'b1;
            end
            if (w_finish) begin
                r_ovalid <= 1'b1;
                if (r_alast) begin
                    // end of problem
                    r_bcnt <= '0;
                    r_qcnt <= '0;
                    r_kept <= '0;
                end else begin
                    r_kept <= w_kept_next;
                end
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_s_axis_tuser) begin
            r_aval  <= i_s_axis_tdata;
            r_alast <= i_s_axis_tlast;
        end
        if (w_finish) begin
            r_oval  <= r_aval;
            r_ocnt  <= w_kept_next;
            r_okept <= w_keep;
            r_olast <= r_alast;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {r_ocnt, r_oval};
    assign o_m_axis_tuser  = r_okept;
    assign o_m_axis_tlast  = r_olast;

`ifndef ASSERT_OFF
    // entries left past the pointer never exceed entries written
    a_qcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt <= r_bcnt)
        else $error("pointer queue larger than B count");

    // a pop takes exactly one entry off the head
    a_pop_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (r_qcnt == $past(r_qcnt) - 1'b1))
        else $error("pop did not decrement queue");

    // finishing the last A element clears the problem
    a_last_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_finish && r_alast) |=> (r_bcnt == '0 && r_qcnt == '0 && r_kept == '0))
        else $error("problem state not cleared after last element");

    // no request is taken while an A element is still walking
    a_walk_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && !w_finish) |=> !o_s_axis_tready)
        else $error("request accepted during walk");
`endif

endmodule
